// ===== src/mch_pkg.sv =====
`default_nettype none
package mch_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_MSG   = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_DOWN  = 2'd3;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HELLO   = 4'd1;
    localparam logic [3:0] PH_EPMAP   = 4'd2;
    localparam logic [3:0] PH_IOP_ON  = 4'd3;
    localparam logic [3:0] PH_AP_ON   = 4'd4;
    localparam logic [3:0] PH_RUN     = 4'd5;
    localparam logic [3:0] PH_QUIESCE = 4'd6;
    localparam logic [3:0] PH_TARGET  = 4'd7;
    localparam logic [3:0] PH_DOWN    = 4'd8;
    localparam logic [3:0] PH_FAIL    = 4'd9;
    localparam logic [3:0] PH_CRASH   = 4'd10;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_EP      = 3'd1;
    localparam logic [2:0] ERR_TYPE    = 3'd2;
    localparam logic [2:0] ERR_VERSION = 3'd3;
    localparam logic [2:0] ERR_TIMEOUT = 3'd4;
    localparam logic [2:0] ERR_CRASH   = 3'd5;
    localparam logic [2:0] ERR_NOTNOW  = 3'd6;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_IOP    = 2'd1;
    localparam logic [1:0] KIND_HOST   = 2'd2;

    localparam logic [1:0] REG_MIN_VER   = 2'd0;
    localparam logic [1:0] REG_MAX_VER   = 2'd1;
    localparam logic [1:0] REG_REPLY_TO  = 2'd2;
    localparam logic [1:0] REG_POWER_TO  = 2'd3;

    localparam logic [15:0] PWR_INIT     = 16'h0220;
    localparam logic [15:0] PWR_ON       = 16'h0020;
    localparam logic [15:0] PWR_QUIESCED = 16'h0010;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] msg_payload;
        logic [7:0]  msg_endpoint;
        logic [15:0] target_power;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] payload;
        logic [7:0]  endpoint;
        logic [3:0]  phase;
        logic [2:0]  error;
        logic        last;
    } result_t;

    function automatic logic [63:0] mk(input logic [7:0] typ, input logic [51:0] low);
        mk = {4'd0, typ, low};
    endfunction

endpackage
`default_nettype wire

// ===== src/mch_front.sv =====
`default_nettype none
module mch_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mch_pkg::item_t in_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output mch_pkg::item_t      q_item
);
    import mch_pkg::*;

    // Small queue that decouples acceptance from execution.
    item_t            mem [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     cnt_reg;
    logic             push, pop;

    assign in_ready = (cnt_reg != QAW'(0) + (QAW+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/mch_back.sv =====
`default_nettype none
module mch_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire mch_pkg::item_t   q_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mch_pkg::result_t      out_res
);
    import mch_pkg::*;

    logic [15:0] min_ver_reg, max_ver_reg;
    logic [31:0] reply_to_reg, power_to_reg;
    logic [3:0]  phase_reg;
    logic [15:0] iop_pwr_reg, ap_pwr_reg, target_reg;
    logic [4:0]  present_reg;
    logic [31:0] tcount_reg;
    logic        crashed_reg, granted_reg;

    // Results of the item being emitted, one per cycle from this list while the output is free.
    logic [1:0]  rk_reg [6];
    logic [63:0] rp_reg [6];
    logic [7:0]  re_reg [6];
    logic [2:0]  n_reg, idx_reg;
    logic [3:0]  rph_reg;
    logic [2:0]  rerr_reg;
    logic        busy_reg;

    // Combinational evaluation of one item.
    logic [1:0]  ck [6];
    logic [63:0] cp [6];
    logic [7:0]  ce [6];
    logic [2:0]  cn;
    logic [3:0]  ph;
    logic [15:0] iop, ap, tgt;
    logic [4:0]  pres;
    logic [31:0] tc;
    logic        crs, grt;
    logic [2:0]  err;

    logic        out_free;
    logic        take;

    assign out_free = !out_valid || out_ready;
    assign q_ready  = !busy_reg;
    assign take     = q_valid && !busy_reg;

    always_comb
    begin
        logic [7:0]  typ;
        logic [63:0] pay;
        logic [7:0]  ep;
        logic [15:0] imin, imax, want;
        logic [2:0]  base;
        logic [3:0]  prev_phase;
        logic [31:0] limit;
        logic        dowait;
        typ  = q_item.msg_payload[59:52];
        pay  = q_item.msg_payload;
        ep   = q_item.msg_endpoint;
        imin = pay[15:0];
        imax = pay[31:16];
        want = (imax < max_ver_reg) ? imax : max_ver_reg;
        base = pay[34:32];
        prev_phase = phase_reg;
        limit = '0;
        dowait = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            ck[i] = KIND_STATUS;
            cp[i] = '0;
            ce[i] = '0;
        end
        cn = '0;
        ph = phase_reg; iop = iop_pwr_reg; ap = ap_pwr_reg; tgt = target_reg;
        pres = present_reg; tc = tcount_reg; crs = crashed_reg; grt = granted_reg;
        err = ERR_NONE;

        priority if (q_item.mode == MODE_TICK)
        begin
            if (!crs)
            begin
                dowait = 1'b1;
            end
        end
        else if (crs)
        begin
            err = ERR_CRASH;
        end
        else if (q_item.mode == MODE_START || q_item.mode == MODE_DOWN)
        begin
            if (!(ph == PH_IDLE || ph == PH_RUN || ph == PH_DOWN || ph == PH_FAIL))
            begin
                err = ERR_NOTNOW;
            end
            else if (q_item.mode == MODE_START)
            begin
                ck[0] = KIND_IOP; cp[0] = mk(8'h06, 52'(PWR_INIT)); cn = 3'd1;
                ph = PH_HELLO; tc = '0; pres = '0;
            end
            else
            begin
                tgt = q_item.target_power;
                ck[0] = KIND_IOP; cp[0] = mk(8'h0b, 52'(PWR_QUIESCED)); cn = 3'd1;
                ph = PH_QUIESCE;
                dowait = 1'b1;
            end
        end
        else if (ph == PH_HELLO)
        begin
            priority if (ep != 8'd0) err = ERR_EP;
            else if (typ != 8'd1) err = ERR_TYPE;
            else if (imin > max_ver_reg || imax < min_ver_reg) err = ERR_VERSION;
            else
            begin
                ck[0] = KIND_IOP; cp[0] = mk(8'h02, {20'd0, want, want}); cn = 3'd1;
                ph = PH_EPMAP; tc = '0;
            end
        end
        else if (ph == PH_EPMAP)
        begin
            priority if (ep != 8'd0) err = ERR_EP;
            else if (typ != 8'd8) err = ERR_TYPE;
            else
            begin
                if (base == 3'd0)
                begin
                    pres = pres | {pay[8], pay[4], pay[3], pay[2], pay[1]};
                end
                tc = '0;
                ck[0] = KIND_IOP;
                if (!pay[51])
                begin
                    cp[0] = mk(8'h08, {17'd0, base, 32'd1}); cn = 3'd1;
                end
                else
                begin
                    cp[0] = mk(8'h08, {1'b1, 16'd0, base, 32'd0});
                    cn = 3'd1;
                    if (pres[2]) begin ck[cn] = KIND_IOP;
                        cp[cn] = mk(8'h05, {20'd3, 32'd2}); cn = cn + 3'd1; end
                    if (pres[0]) begin ck[cn] = KIND_IOP;
                        cp[cn] = mk(8'h05, {20'd1, 32'd2}); cn = cn + 3'd1; end
                    if (pres[1]) begin ck[cn] = KIND_IOP;
                        cp[cn] = mk(8'h05, {20'd2, 32'd2}); cn = cn + 3'd1; end
                    if (pres[3]) begin ck[cn] = KIND_IOP;
                        cp[cn] = mk(8'h05, {20'd4, 32'd2}); cn = cn + 3'd1; end
                    if (pres[4]) begin ck[cn] = KIND_IOP;
                        cp[cn] = mk(8'h05, {20'd8, 32'd2}); cn = cn + 3'd1; end
                    ph = PH_IOP_ON;
                end
            end
        end
        else
        begin
            dowait = 1'b1;
            if (ep >= 8'h20)
            begin
                ck[0] = KIND_HOST; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                dowait = 1'b0;
            end
            else
            begin
                unique case (ep)
                    8'd0:
                    begin
                        if (typ == 8'h07) iop = pay[15:0];
                        else if (typ == 8'h0b) ap = pay[15:0];
                    end
                    8'd1:
                    begin
                        if (typ == 8'h01)
                        begin
                            if (!grt)
                            begin
                                grt = 1'b1;
                                ck[0] = KIND_HOST; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                            end
                            else
                            begin
                                crs = 1'b1; ph = PH_CRASH; err = ERR_CRASH;
                                dowait = 1'b0;
                            end
                        end
                    end
                    8'd2:
                    begin
                        if (typ == 8'h01)
                        begin
                            ck[0] = KIND_HOST; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                        end
                        else if (typ == 8'h05)
                        begin
                            ck[0] = KIND_IOP; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                        end
                    end
                    8'd4:
                    begin
                        if (typ == 8'h01)
                        begin
                            ck[0] = KIND_HOST; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                        end
                        else if (typ == 8'h08 || typ == 8'h0c)
                        begin
                            ck[0] = KIND_IOP; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                        end
                    end
                    8'd8:
                    begin
                        if (pay[63:56] == 8'd1)
                        begin
                            ck[0] = KIND_HOST; cp[0] = pay; ce[0] = ep; cn = 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Pending power transitions; at most one message results here.
        if (dowait)
        begin
            if (ph == PH_IOP_ON && iop == PWR_ON)
            begin
                ck[cn] = KIND_IOP; cp[cn] = mk(8'h0b, 52'(PWR_ON)); ce[cn] = '0;
                cn = cn + 3'd1;
                if (power_to_reg == '0) ph = PH_RUN;
                else begin ph = PH_AP_ON; tc = '0; end
            end
            if (ph == PH_AP_ON && ap == PWR_ON) ph = PH_RUN;
            if (ph == PH_QUIESCE && ap == PWR_QUIESCED)
            begin
                ck[cn] = KIND_IOP; cp[cn] = mk(8'h06, {36'd0, tgt}); ce[cn] = '0;
                cn = cn + 3'd1;
                ph = PH_TARGET;
            end
            if (ph == PH_TARGET && iop == tgt) ph = PH_DOWN;
        end

        if (q_item.mode == MODE_TICK && !crs && ph == prev_phase)
        begin
            if (ph == PH_HELLO || ph == PH_EPMAP) limit = reply_to_reg;
            else if (ph == PH_IOP_ON || ph == PH_AP_ON) limit = power_to_reg;
            if (limit != '0)
            begin
                if (tc != 32'hFFFF_FFFF) tc = tc + 32'd1;
                if (tc >= limit)
                begin
                    ph = PH_FAIL; err = ERR_TIMEOUT;
                end
            end
        end

        if (err != ERR_NONE && err != ERR_CRASH && q_item.mode == MODE_MSG)
        begin
            ph = PH_FAIL;
        end
        if (err != ERR_NONE)
        begin
            cn = '0;
        end
        if (cn == '0)
        begin
            ck[0] = KIND_STATUS; cp[0] = '0; ce[0] = '0; cn = 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 6; i++)
            begin
                rk_reg[i] <= ck[i];
                rp_reg[i] <= cp[i];
                re_reg[i] <= ce[i];
            end
            rph_reg  <= ph;
            rerr_reg <= err;
            n_reg    <= cn;
        end
        if (busy_reg && out_free)
        begin
            out_res.kind     <= rk_reg[idx_reg];
            out_res.payload  <= rp_reg[idx_reg];
            out_res.endpoint <= re_reg[idx_reg];
            out_res.phase    <= rph_reg;
            out_res.error    <= rerr_reg;
            out_res.last     <= (idx_reg + 3'd1 == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ver_reg  <= 16'd11;
            max_ver_reg  <= 16'd12;
            reply_to_reg <= 32'd1000000;
            power_to_reg <= '0;
            phase_reg    <= PH_IDLE;
            iop_pwr_reg  <= '0;
            ap_pwr_reg   <= '0;
            target_reg   <= '0;
            present_reg  <= '0;
            tcount_reg   <= '0;
            crashed_reg  <= 1'b0;
            granted_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_VER:  min_ver_reg  <= cfg_data[15:0];
                    REG_MAX_VER:  max_ver_reg  <= cfg_data[15:0];
                    REG_REPLY_TO: reply_to_reg <= cfg_data;
                    REG_POWER_TO: power_to_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take)
            begin
                phase_reg   <= ph;
                iop_pwr_reg <= iop;
                ap_pwr_reg  <= ap;
                target_reg  <= tgt;
                present_reg <= pres;
                tcount_reg  <= tc;
                crashed_reg <= crs;
                granted_reg <= grt;
                busy_reg    <= 1'b1;
                idx_reg     <= '0;
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (busy_reg && out_free)
            begin
                out_valid <= 1'b1;
                if (idx_reg + 3'd1 == n_reg)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/mailbox_coprocessor_handshake_unit.sv =====
`default_nettype none
// Management-side handshake engine for a mailbox coprocessor. Items enter on
// the slave stream, with the mode on s_tuser, and go into a four-entry queue,
// so the upstream side keeps handing over items while the back end is busy.
// The back end evaluates one item in the cycle it is taken from the queue,
// updating the handshake phase, power states, endpoint flags and timeout
// counter, then emits its one to six result items at one per cycle while
// the output is not stalled, through a registered output, with the result
// kind on m_tuser and m_tlast on the final result of the item. As the
// result list register holds one item, no new item is taken until its last
// result has gone out. The user must write registers through the plain
// write port only while no item is in flight; the block does not enforce it.
module mailbox_coprocessor_handshake_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tuser from bit 0: mode[1:0].
    input  wire logic [1:0]   s_tuser,
    // s_tdata from bit 0: msg_payload[63:0], msg_endpoint[71:64],
    // target_power[87:72].
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tuser from bit 0: kind[1:0].
    output logic [1:0]        m_tuser,
    // m_tdata from bit 0: payload[63:0], endpoint[71:64], phase[75:72],
    // error[78:76], zero fill to 80 bits.
    output logic [79:0]       m_tdata,
    output logic              m_tlast
);
    import mch_pkg::*;

    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_ready;

    assign in_item.mode         = s_tuser;
    assign in_item.msg_payload  = s_tdata[63:0];
    assign in_item.msg_endpoint = s_tdata[71:64];
    assign in_item.target_power = s_tdata[87:72];

    mch_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    mch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {1'b0, res.error, res.phase, res.endpoint, res.payload};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule
`default_nettype wire

// ===== dv/mailbox_coprocessor_handshake_unit_tb.sv =====
`default_nettype none
module mailbox_coprocessor_handshake_unit_tb;
    import mch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Message types that appear in bits 59..52 of a mailbox word.
    localparam logic [7:0] MT_HELLO    = 8'h01; // also buffer request on system endpoints
    localparam logic [7:0] MT_HELLO_RP = 8'h02;
    localparam logic [7:0] MT_SYSLOG   = 8'h05; // also endpoint start
    localparam logic [7:0] MT_IOP_PWR  = 8'h06;
    localparam logic [7:0] MT_IOP_ACK  = 8'h07;
    localparam logic [7:0] MT_EPMAP    = 8'h08; // also ioreport echo
    localparam logic [7:0] MT_AP_PWR   = 8'h0b;
    localparam logic [7:0] MT_IOREPORT = 8'h0c;

    // Endpoint numbers of the system endpoints and of the first app endpoint.
    localparam logic [7:0] EP_MGMT     = 8'd0;
    localparam logic [7:0] EP_CRASHLOG = 8'd1;
    localparam logic [7:0] EP_SYSLOG   = 8'd2;
    localparam logic [7:0] EP_DEBUG    = 8'd3;
    localparam logic [7:0] EP_IOREPORT = 8'd4;
    localparam logic [7:0] EP_OSLOG    = 8'd8;
    localparam logic [7:0] EP_APP      = 8'h20;

    localparam int MAX_RES = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [79:0] m_tdata;
    logic        m_tlast;

    mailbox_coprocessor_handshake_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Items waiting to be driven, and the results the block owes us.
    item_t   pending_items[$];
    result_t expected_results[$];
    result_t step_results[$];

    int  n_queued;
    int  n_taken;
    int  n_errors;
    bit  item_taken;
    bit  idling_on;
    int  send_gap;
    int  recv_stall;

    // Shadow copy of the configuration registers.
    logic [15:0] cfg_min_ver;
    logic [15:0] cfg_max_ver;
    logic [31:0] cfg_reply_to;
    logic [31:0] cfg_power_to;

    // Shadow copy of the handshake state.
    logic [3:0]  sh_phase;
    logic [15:0] sh_iop_pwr;
    logic [15:0] sh_ap_pwr;
    logic [4:0]  sh_ep_present;
    logic [31:0] sh_tmo_cnt;
    logic        sh_crashed;
    logic        sh_clog_granted;
    logic [15:0] sh_sd_target;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [63:0] msg_word(input logic [7:0] typ, input logic [51:0] low);
        msg_word = {4'd0, typ, low};
    endfunction

    // A result is kept only while the list has room, as in the block.
    task automatic add_result(input logic [1:0] kind, input logic [63:0] pay,
                              input logic [7:0] ep);
        result_t r;
        if (step_results.size() < MAX_RES)
        begin
            r = '0;
            r.kind = kind;
            r.payload = pay;
            r.endpoint = ep;
            step_results.push_back(r);
        end
    endtask

    // Moves out of the power waits once the matching state has been reported.
    task automatic advance_power_waits();
        if (sh_phase == PH_IOP_ON && sh_iop_pwr == PWR_ON)
        begin
            add_result(KIND_IOP, msg_word(MT_AP_PWR, 52'(PWR_ON)), EP_MGMT);
            if (cfg_power_to == 0)
                sh_phase = PH_RUN;
            else
            begin
                sh_phase = PH_AP_ON;
                sh_tmo_cnt = 0;
            end
        end
        if (sh_phase == PH_AP_ON && sh_ap_pwr == PWR_ON)
            sh_phase = PH_RUN;
        if (sh_phase == PH_QUIESCE && sh_ap_pwr == PWR_QUIESCED)
        begin
            add_result(KIND_IOP, msg_word(MT_IOP_PWR, 52'(sh_sd_target)), EP_MGMT);
            sh_phase = PH_TARGET;
        end
        if (sh_phase == PH_TARGET && sh_iop_pwr == sh_sd_target)
            sh_phase = PH_DOWN;
    endtask

    // Messages outside the hello and endpoint-map phases: power reports, echoes,
    // forwards to the host, and the crashlog request.
    task automatic handle_message(input logic [63:0] pay, input logic [7:0] ep,
                                  output logic [2:0] err);
        logic [7:0] typ;
        typ = pay[59:52];
        err = ERR_NONE;
        if (ep >= EP_APP)
        begin
            add_result(KIND_HOST, pay, ep);
            return;
        end
        case (ep)
            EP_MGMT:
            begin
                if (typ == MT_IOP_ACK)
                    sh_iop_pwr = pay[15:0];
                else if (typ == MT_AP_PWR)
                    sh_ap_pwr = pay[15:0];
            end
            EP_CRASHLOG:
            begin
                if (typ == MT_HELLO)
                begin
                    if (!sh_clog_granted)
                    begin
                        sh_clog_granted = 1'b1;
                        add_result(KIND_HOST, pay, ep);
                    end
                    else
                    begin
                        // A second crashlog request means the coprocessor died.
                        sh_crashed = 1'b1;
                        sh_phase = PH_CRASH;
                        err = ERR_CRASH;
                        return;
                    end
                end
            end
            EP_SYSLOG:
            begin
                if (typ == MT_HELLO)
                    add_result(KIND_HOST, pay, ep);
                else if (typ == MT_SYSLOG)
                    add_result(KIND_IOP, pay, ep);
            end
            EP_IOREPORT:
            begin
                if (typ == MT_HELLO)
                    add_result(KIND_HOST, pay, ep);
                else if (typ == MT_EPMAP || typ == MT_IOREPORT)
                    add_result(KIND_IOP, pay, ep);
            end
            EP_OSLOG:
            begin
                if (pay[63:56] == 8'd1)
                    add_result(KIND_HOST, pay, ep);
            end
            default: ;
        endcase
        advance_power_waits();
    endtask

    // Version negotiation: the answer takes the highest version both sides know.
    task automatic handle_hello(input logic [63:0] pay, input logic [7:0] ep,
                                output logic [2:0] err);
        logic [15:0] their_min;
        logic [15:0] their_max;
        logic [15:0] chosen;
        their_min = pay[15:0];
        their_max = pay[31:16];
        err = ERR_NONE;
        if (ep != EP_MGMT)
            err = ERR_EP;
        else if (pay[59:52] != MT_HELLO)
            err = ERR_TYPE;
        else if (their_min > cfg_max_ver || their_max < cfg_min_ver)
            err = ERR_VERSION;
        else
        begin
            chosen = (their_max < cfg_max_ver) ? their_max : cfg_max_ver;
            add_result(KIND_IOP, msg_word(MT_HELLO_RP, {20'd0, chosen, chosen}), EP_MGMT);
            sh_phase = PH_EPMAP;
            sh_tmo_cnt = 0;
        end
    endtask

    // One endpoint-map chunk; only base zero names system endpoints.
    task automatic handle_epmap(input logic [63:0] pay, input logic [7:0] ep,
                                output logic [2:0] err);
        logic [2:0]  base;
        logic [31:0] bits;
        err = ERR_NONE;
        if (ep != EP_MGMT)
        begin
            err = ERR_EP;
            return;
        end
        if (pay[59:52] != MT_EPMAP)
        begin
            err = ERR_TYPE;
            return;
        end
        base = pay[34:32];
        bits = pay[31:0];
        if (base == 0)
        begin
            if (bits[1]) sh_ep_present[0] = 1'b1;
            if (bits[2]) sh_ep_present[1] = 1'b1;
            if (bits[3]) sh_ep_present[2] = 1'b1;
            if (bits[4]) sh_ep_present[3] = 1'b1;
            if (bits[8]) sh_ep_present[4] = 1'b1;
        end
        sh_tmo_cnt = 0;
        if (!pay[51])
        begin
            add_result(KIND_IOP, msg_word(MT_EPMAP, {17'd0, base, 32'd1}), EP_MGMT);
            return;
        end
        add_result(KIND_IOP, msg_word(MT_EPMAP, {17'd0, base, 32'd0} | (52'd1 << 51)),
                   EP_MGMT);
        // Start messages go out in the fixed order debug, crashlog, syslog,
        // ioreport, oslog.
        if (sh_ep_present[2])
            add_result(KIND_IOP, msg_word(MT_SYSLOG, {12'd0, 8'(EP_DEBUG), 32'd2}), EP_MGMT);
        if (sh_ep_present[0])
            add_result(KIND_IOP, msg_word(MT_SYSLOG, {12'd0, 8'(EP_CRASHLOG), 32'd2}),
                       EP_MGMT);
        if (sh_ep_present[1])
            add_result(KIND_IOP, msg_word(MT_SYSLOG, {12'd0, 8'(EP_SYSLOG), 32'd2}), EP_MGMT);
        if (sh_ep_present[3])
            add_result(KIND_IOP, msg_word(MT_SYSLOG, {12'd0, 8'(EP_IOREPORT), 32'd2}),
                       EP_MGMT);
        if (sh_ep_present[4])
            add_result(KIND_IOP, msg_word(MT_SYSLOG, {12'd0, 8'(EP_OSLOG), 32'd2}), EP_MGMT);
        sh_phase = PH_IOP_ON;
    endtask

    task automatic handle_tick(output logic [2:0] err);
        logic [3:0]  prev_phase;
        logic [31:0] limit;
        err = ERR_NONE;
        if (sh_crashed)
            return;
        prev_phase = sh_phase;
        advance_power_waits();
        if (sh_phase != prev_phase)
            return;
        if (sh_phase == PH_HELLO || sh_phase == PH_EPMAP)
            limit = cfg_reply_to;
        else if (sh_phase == PH_IOP_ON || sh_phase == PH_AP_ON)
            limit = cfg_power_to;
        else
            return;
        if (limit == 0)
            return;
        if (sh_tmo_cnt != 32'hffff_ffff)
            sh_tmo_cnt++;
        if (sh_tmo_cnt >= limit)
        begin
            sh_phase = PH_FAIL;
            err = ERR_TIMEOUT;
        end
    endtask

    function automatic bit start_allowed();
        start_allowed = (sh_phase == PH_IDLE || sh_phase == PH_RUN ||
                         sh_phase == PH_DOWN || sh_phase == PH_FAIL);
    endfunction

    // Works out every result of one accepted item and queues them in order.
    task automatic predict_handshake(input item_t it);
        logic [2:0] err;
        result_t    r;
        step_results.delete();
        err = ERR_NONE;
        if (it.mode == MODE_TICK)
            handle_tick(err);
        else if (sh_crashed)
            err = ERR_CRASH;
        else if (it.mode == MODE_START)
        begin
            if (!start_allowed())
                err = ERR_NOTNOW;
            else
            begin
                add_result(KIND_IOP, msg_word(MT_IOP_PWR, 52'(PWR_INIT)), EP_MGMT);
                sh_phase = PH_HELLO;
                sh_tmo_cnt = 0;
                sh_ep_present = '0;
            end
        end
        else if (it.mode == MODE_DOWN)
        begin
            if (!start_allowed())
                err = ERR_NOTNOW;
            else
            begin
                sh_sd_target = it.target_power;
                add_result(KIND_IOP, msg_word(MT_AP_PWR, 52'(PWR_QUIESCED)), EP_MGMT);
                sh_phase = PH_QUIESCE;
                advance_power_waits();
            end
        end
        else
        begin
            if (sh_phase == PH_HELLO)
                handle_hello(it.msg_payload, it.msg_endpoint, err);
            else if (sh_phase == PH_EPMAP)
                handle_epmap(it.msg_payload, it.msg_endpoint, err);
            else
                handle_message(it.msg_payload, it.msg_endpoint, err);
            if (err != ERR_NONE && err != ERR_CRASH)
                sh_phase = PH_FAIL;
        end
        if (err != ERR_NONE)
            step_results.delete();
        if (step_results.size() == 0)
            add_result(KIND_STATUS, 64'd0, 8'd0);
        foreach (step_results[k])
        begin
            r = step_results[k];
            r.phase = sh_phase;
            r.error = err;
            r.last = (k == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Acceptance of items and of results is judged at the rising edge. The
    // item is predicted before the result is checked, although the block can
    // never answer within the same cycle.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_taken = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            item_taken = 1'b1;
            n_taken++;
            predict_handshake(item_t'({s_tuser, s_tdata[63:0], s_tdata[71:64],
                                       s_tdata[87:72]}));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.payload = m_tdata[63:0];
            got.endpoint = m_tdata[71:64];
            got.phase = m_tdata[75:72];
            got.error = m_tdata[78:76];
            got.last = m_tlast;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got), 64'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.payload !== want.payload)
                    report_mismatch("payload", got.payload, want.payload);
                if (got.endpoint !== want.endpoint)
                    report_mismatch("endpoint", 64'(got.endpoint), 64'(want.endpoint));
                if (got.phase !== want.phase)
                    report_mismatch("phase", 64'(got.phase), 64'(want.phase));
                if (got.error !== want.error)
                    report_mismatch("error", 64'(got.error), 64'(want.error));
                if (got.last !== want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    // Item driver: holds an item until it is taken, then loads the next one or
    // sits out a random gap.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || item_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                s_tuser <= it.mode;
                s_tdata <= {it.target_power, it.msg_endpoint, it.msg_payload};
                s_tvalid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver with random stall bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 6) == 0)
                    recv_stall = $urandom_range(1, 9);
            end
        end
    end

    task automatic queue_item(input logic [1:0] mode, input logic [63:0] pay,
                              input logic [7:0] ep, input logic [15:0] tp);
        item_t it;
        it.mode = mode;
        it.msg_payload = pay;
        it.msg_endpoint = ep;
        it.target_power = tp;
        pending_items.push_back(it);
        n_queued++;
    endtask

    // Message on the management endpoint with random noise in target_power.
    task automatic queue_mgmt(input logic [7:0] typ, input logic [51:0] low);
        queue_item(MODE_MSG, msg_word(typ, low), EP_MGMT, 16'($urandom));
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            queue_item(MODE_TICK, {$urandom, $urandom}, 8'($urandom), 16'($urandom));
    endtask

    // Waits until every item is in and every result is out, then lets the
    // block settle before a register write.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_taken != n_queued || expected_results.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_VER:  cfg_min_ver = val[15:0];
            REG_MAX_VER:  cfg_max_ver = val[15:0];
            REG_REPLY_TO: cfg_reply_to = val;
            default:      cfg_power_to = val;
        endcase
    endtask

    // A random but mostly well-formed boot, run and power-down sequence,
    // with occasional faults and stray items thrown in.
    task automatic queue_session();
        logic [15:0] vlo;
        logic [15:0] vhi;
        logic [15:0] tgt;
        logic [2:0]  base;
        int          chunks;
        if ($urandom_range(0, 9) == 0)
        begin
            queue_item(2'($urandom), {$urandom, $urandom}, 8'($urandom), 16'($urandom));
            return;
        end
        queue_item(MODE_START, {$urandom, $urandom}, 8'($urandom), 16'($urandom));
        queue_ticks($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
        begin
            vlo = 16'($urandom);
            vhi = 16'($urandom);
        end
        else
        begin
            vlo = cfg_min_ver - 16'($urandom_range(0, 1));
            vhi = cfg_max_ver + 16'($urandom_range(0, 1));
        end
        if ($urandom_range(0, 11) == 0)
            queue_item(MODE_MSG, msg_word(8'($urandom_range(0, 3)), {20'd0, vhi, vlo}),
                       8'($urandom_range(0, 1)), 16'd0);
        else
            queue_mgmt(MT_HELLO, 52'({$urandom, vhi, vlo}));
        chunks = $urandom_range(1, 3);
        for (int c = 0; c < chunks; c++)
        begin
            queue_ticks($urandom_range(0, 2));
            base = (c == 0) ? 3'd0 : 3'($urandom);
            queue_mgmt(MT_EPMAP, (52'({$urandom, base, $urandom}) & ~(52'd1 << 51)) |
                       (52'(c == chunks - 1) << 51));
        end
        queue_ticks($urandom_range(0, 3));
        if ($urandom_range(0, 1))
            queue_mgmt(MT_AP_PWR, 52'(PWR_ON));
        queue_mgmt(MT_IOP_ACK, {$urandom, 4'd0, 16'(PWR_ON)} & 52'hf_ffff_ffff_ffff);
        queue_ticks($urandom_range(0, 2));
        queue_mgmt(MT_AP_PWR, 52'(PWR_ON));
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0: queue_item(MODE_MSG, msg_word(MT_SYSLOG, 52'({$urandom, $urandom})),
                              EP_SYSLOG, 16'd0);
                1: queue_item(MODE_MSG, msg_word($urandom_range(0, 1) ? MT_EPMAP : MT_IOREPORT,
                              52'({$urandom, $urandom})), EP_IOREPORT, 16'd0);
                2: queue_item(MODE_MSG, {$urandom, $urandom}, 8'($urandom_range(32, 255)),
                              16'd0);
                3: queue_item(MODE_MSG, {8'd1, 56'({$urandom, $urandom})}, EP_OSLOG, 16'd0);
                4: queue_item(MODE_MSG, msg_word(MT_HELLO, 52'({$urandom, $urandom})),
                              $urandom_range(0, 1) ? EP_SYSLOG : EP_IOREPORT, 16'd0);
                default: queue_item(MODE_MSG, {$urandom, $urandom},
                                    8'($urandom_range(0, 31)), 16'd0);
            endcase
        end
        if ($urandom_range(0, 3) != 0)
        begin
            tgt = $urandom_range(0, 1) ? PWR_QUIESCED : 16'd1;
            queue_item(MODE_DOWN, {$urandom, $urandom}, 8'($urandom), tgt);
            queue_mgmt(MT_AP_PWR, 52'(PWR_QUIESCED));
            queue_mgmt(MT_IOP_ACK, 52'(tgt));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        n_queued = 0;
        n_taken = 0;
        n_errors = 0;
        send_gap = 0;
        recv_stall = 0;
        idling_on = 1'b1;
        cfg_min_ver = 16'h000b;
        cfg_max_ver = 16'h000c;
        cfg_reply_to = 32'd1_000_000;
        cfg_power_to = 32'd0;
        sh_phase = PH_IDLE;
        sh_iop_pwr = '0;
        sh_ap_pwr = '0;
        sh_ep_present = '0;
        sh_tmo_cnt = '0;
        sh_crashed = 1'b0;
        sh_clog_granted = 1'b0;
        sh_sd_target = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with reset register values: a full boot with every
        // system endpoint, the echo and forward paths, a power down to the
        // quiesced state, and the hello faults.
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);      // refused while waiting
        queue_mgmt(MT_HELLO, {20'd0, 16'h000c, 16'h000b});
        queue_mgmt(MT_EPMAP, 52'h0_0000_0000_011e);
        queue_mgmt(MT_EPMAP, (52'd1 << 51) | 52'h1_ffff_ffff);  // base not zero
        queue_mgmt(MT_IOP_ACK, 52'(PWR_ON));
        queue_mgmt(MT_AP_PWR, 52'(PWR_ON));
        queue_item(MODE_MSG, msg_word(MT_SYSLOG, 52'h1234), EP_SYSLOG, 16'd0);
        queue_item(MODE_MSG, msg_word(MT_IOREPORT, 52'h55), EP_IOREPORT, 16'd0);
        queue_item(MODE_MSG, 64'hffff_ffff_ffff_ffff, 8'hff, 16'hffff);
        queue_item(MODE_MSG, msg_word(MT_HELLO, 52'h42), EP_CRASHLOG, 16'd0);
        queue_item(MODE_MSG, 64'h01ff_ffff_ffff_ffff, EP_OSLOG, 16'd0);
        queue_item(MODE_MSG, 64'h0, 8'd7, 16'd0);        // unknown endpoint
        queue_item(MODE_DOWN, 64'd0, 8'd0, PWR_QUIESCED);
        queue_mgmt(MT_AP_PWR, 52'(PWR_QUIESCED));
        queue_mgmt(MT_IOP_ACK, 52'(PWR_QUIESCED));
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);
        queue_item(MODE_MSG, msg_word(MT_HELLO, 52'h000c000b), 8'd5, 16'd0);
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);
        queue_mgmt(MT_EPMAP, 52'h000c000b);
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);
        queue_mgmt(MT_HELLO, {20'd0, 16'hffff, 16'hfff0});
        queue_ticks(2);
        wait_idle();

        // Random part across register settings, the extremes among them.
        for (int s = 0; s < 8; s++)
        begin
            case (s)
                0:
                begin
                    write_reg(REG_MIN_VER, 32'd0);
                    write_reg(REG_MAX_VER, 32'hffff);
                    write_reg(REG_REPLY_TO, 32'd0);
                    write_reg(REG_POWER_TO, 32'hffff_ffff);
                end
                1:
                begin
                    write_reg(REG_MIN_VER, 32'h000b);
                    write_reg(REG_MAX_VER, 32'h000c);
                    write_reg(REG_REPLY_TO, 32'd2);
                    write_reg(REG_POWER_TO, 32'd1);
                end
                2:
                begin
                    write_reg(REG_REPLY_TO, 32'hffff_ffff);
                    write_reg(REG_POWER_TO, 32'd0);
                end
                default:
                begin
                    write_reg(REG_MIN_VER, $urandom_range(0, 20));
                    write_reg(REG_MAX_VER, $urandom_range(10, 40));
                    write_reg(REG_REPLY_TO, $urandom_range(0, 4));
                    write_reg(REG_POWER_TO, $urandom_range(0, 4));
                end
            endcase
            if (s == 7)
                idling_on = 1'b0;
            while (n_queued < 40 + 36 * (s + 1))
                queue_session();
            wait_idle();
        end

        // A second crashlog request kills the coprocessor for good, so it
        // comes last.
        write_reg(REG_POWER_TO, 32'd0);
        queue_item(MODE_MSG, msg_word(MT_HELLO, 52'h7), EP_CRASHLOG, 16'd0);
        queue_item(MODE_MSG, msg_word(MT_HELLO, 52'h9), EP_CRASHLOG, 16'd0);
        queue_item(MODE_START, 64'd0, 8'd0, 16'd0);
        queue_item(MODE_DOWN, 64'd0, 8'd0, 16'd1);
        queue_ticks(2);
        queue_mgmt(MT_IOP_ACK, 52'(PWR_ON));
        wait_idle();

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/mch_pkg.sv
src/mch_front.sv
src/mch_back.sv
src/mailbox_coprocessor_handshake_unit.sv
dv/mailbox_coprocessor_handshake_unit_tb.sv
